// ----- hdl/mlsf_pkg.sv -----
package mlsf_pkg;

    // line size for cache-line zero, a power of two
    localparam int unsigned LINE_BYTES = 128;
    localparam int unsigned NB_W       = 9;

    localparam int unsigned IN_W   = 328;
    localparam int unsigned OUT_W  = 216;

    // decode flag positions
    localparam int unsigned K_LOAD  = 0;
    localparam int unsigned K_STORE = 1;
    localparam int unsigned K_SEXT  = 2;
    localparam int unsigned K_FLT   = 3;
    localparam int unsigned K_UPD   = 4;
    localparam int unsigned K_MULTI = 5;
    localparam int unsigned K_BSWAP = 6;

    localparam logic [6:0] IDX_LINE_ZERO = 7'h5f;
    localparam logic [5:0] OP_EXT        = 6'd31;
    localparam logic [5:0] OP_DS_FIRST   = 6'd56;

    // configuration register indexes
    localparam logic [7:0] CFG_REBUILD = 8'd0;
    localparam logic [7:0] CFG_ROUND   = 8'd1;

    typedef enum logic [1:0] {
        ST_HANDLED     = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_BAD_ADDR    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RND_NEAREST = 2'd0,
        RND_ZERO    = 2'd1,
        RND_UP      = 2'd2,
        RND_DOWN    = 2'd3
    } t_round;

    typedef struct packed {
        logic [NB_W-1:0] nbytes;
        logic [6:0]      kind;
    } t_desc;

    typedef struct packed {
        logic [31:0] syndrome;
        logic [31:0] instruction_word;
        logic [63:0] fault_address;
        logic [63:0] memory_bytes;
        logic [63:0] gpr_value;
        logic [63:0] fpr_value;
        logic        access_fault;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic        gpr_write;
        logic        fpr_write;
        logic [4:0]  target_reg;
        logic [63:0] target_value;
        logic        update_base;
        logic [4:0]  base_reg;
        logic        store_enable;
        logic [63:0] store_address;
        logic [7:0]  store_length;
        logic [63:0] store_data;
    } t_result;

    localparam logic [6:0] L  = 7'h01;
    localparam logic [6:0] S  = 7'h02;
    localparam logic [6:0] X  = 7'h04;
    localparam logic [6:0] F  = 7'h08;
    localparam logic [6:0] U  = 7'h10;
    localparam logic [6:0] M  = 7'h20;
    localparam logic [6:0] B  = 7'h40;

    function automatic t_desc mk(input int unsigned n, input logic [6:0] k);
        t_desc d;
        d.nbytes = NB_W'(n);
        d.kind   = k;
        return d;
    endfunction

    // operation table; zero-length entries all read as unsupported
    function automatic t_desc op_decode(input logic [6:0] idx);
        t_desc d;
        d = mk(0, 7'h00);
        case (idx)
            7'd0:   d = mk(4, L);
            7'd2:   d = mk(4, S);
            7'd4:   d = mk(2, L);
            7'd5:   d = mk(2, L|X);
            7'd6:   d = mk(2, S);
            7'd7:   d = mk(4, L|M);
            7'd8:   d = mk(4, L|F);
            7'd9:   d = mk(8, L|F);
            7'd10:  d = mk(4, S|F);
            7'd11:  d = mk(8, S|F);
            7'd13:  d = mk(8, L);
            7'd15:  d = mk(8, S);
            7'd16:  d = mk(4, L|U);
            7'd18:  d = mk(4, S|U);
            7'd20:  d = mk(2, L|U);
            7'd21:  d = mk(2, L|X|U);
            7'd22:  d = mk(2, S|U);
            7'd23:  d = mk(4, S|M);
            7'd24:  d = mk(4, L|F|U);
            7'd25:  d = mk(8, L|F|U);
            7'd26:  d = mk(4, S|F|U);
            7'd27:  d = mk(8, S|F|U);
            7'd32:  d = mk(8, L);
            7'd34:  d = mk(8, S);
            7'd37:  d = mk(4, L|X);
            7'd45:  d = mk(8, L|U);
            7'd47:  d = mk(8, S|U);
            7'd48:  d = mk(8, L|U);
            7'd50:  d = mk(8, S|U);
            7'd53:  d = mk(4, L|X|U);
            7'd72:  d = mk(4, L|B);
            7'd74:  d = mk(4, S|B);
            7'd76:  d = mk(2, L|B);
            7'd77:  d = mk(4, L|X);
            7'd78:  d = mk(2, S|B);
            7'd95:  d = mk(LINE_BYTES, S);
            7'd96:  d = mk(4, L);
            7'd98:  d = mk(4, S);
            7'd100: d = mk(2, L);
            7'd101: d = mk(2, L|X);
            7'd102: d = mk(2, S);
            7'd104: d = mk(4, L|F);
            7'd105: d = mk(8, L|F);
            7'd106: d = mk(4, S|F);
            7'd107: d = mk(8, S|F);
            7'd109: d = mk(8, L|M);
            7'd111: d = mk(8, S|M);
            7'd112: d = mk(4, L|U);
            7'd114: d = mk(4, S|U);
            7'd116: d = mk(2, L|U);
            7'd117: d = mk(2, L|X|U);
            7'd118: d = mk(2, S|U);
            7'd120: d = mk(4, L|F|U);
            7'd121: d = mk(8, L|F|U);
            7'd122: d = mk(4, S|F|U);
            7'd123: d = mk(8, S|F|U);
            default: d = mk(0, 7'h00);
        endcase
        return d;
    endfunction

    // syndrome from the instruction word
    function automatic logic [21:0] synd_rebuild(input logic [31:0] w);
        logic [21:0] d;
        d = {12'd0, w[25:16]};
        if (w[31:26] == OP_EXT) begin
            d[16:15] = w[2:1];
            d[14]    = w[6];
            d[13:10] = w[10:7];
        end else begin
            d[14]    = w[26];
            d[13:10] = w[30:27];
            if (w[31:26] >= OP_DS_FIRST) begin
                d[19:18] = w[1:0];
            end
        end
        return d;
    endfunction

    // exact single to double widening
    function automatic logic [63:0] widen_single(input logic [31:0] s);
        logic [7:0]  e8;
        logic [22:0] f;
        logic [4:0]  p;
        logic [4:0]  sh;
        logic [10:0] e;
        logic [45:0] fs;
        e8 = s[30:23];
        f  = s[22:0];
        p  = 5'd0;
        sh = 5'd0;
        e  = 11'd0;
        fs = 46'd0;
        if (e8 == 8'hff) begin
            return {s[31], 11'h7ff, f, 29'd0};
        end
        if (e8 == 8'h00) begin
            if (f == 23'd0) begin
                return {s[31], 63'd0};
            end
            // highest set fraction bit
            for (int i = 0; i < 23; i++) begin
                if (f[i]) begin
                    p = 5'(i);
                end
            end
            sh = 5'd23 - p;
            e  = 11'd897 - 11'(sh);
            fs = {23'd0, f} << sh;
            return {s[31], e, fs[22:0], 29'd0};
        end
        e = 11'(e8) + 11'd896;
        return {s[31], e, f, 29'd0};
    endfunction

    // double to single narrowing with rounding
    function automatic logic [31:0] narrow_double(input logic [63:0] d, input t_round mode);
        logic               neg;
        logic [10:0]        e;
        logic [51:0]        f;
        logic [63:0]        m;
        logic signed [12:0] es;
        logic signed [12:0] s2;
        logic [5:0]         sh;
        logic [63:0]        q;
        logic [63:0]        rem;
        logic [63:0]        half;
        logic               inc;
        logic               to_inf;
        logic [35:0]        bits;
        logic [35:0]        ebase;
        neg = d[63];
        e   = d[62:52];
        f   = d[51:0];
        if (e == 11'h7ff) begin
            if (f == 52'd0) begin
                return {neg, 8'hff, 23'd0};
            end
            return {neg, 8'hff, 1'b1, f[50:29]};
        end
        if (e == 11'd0) begin
            if (f == 52'd0) begin
                return {neg, 31'd0};
            end
            m = {12'd0, f};
            e = 11'd1;
        end else begin
            m = {11'd0, 1'b1, f};
        end
        es = $signed({2'b00, e}) - 13'sd896;
        s2 = 13'sd30 - es;
        sh = 6'd29;
        if (es < 13'sd1) begin
            sh = (s2 > 13'sd63) ? 6'd63 : s2[5:0];
        end
        q    = m >> sh;
        rem  = m & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 6'd1);
        case (mode)
            RND_NEAREST: inc = (rem > half) || ((rem == half) && q[0]);
            RND_ZERO:    inc = 1'b0;
            RND_UP:      inc = !neg && (rem != 64'd0);
            RND_DOWN:    inc = neg && (rem != 64'd0);
            default:     inc = 1'b0;
        endcase
        ebase = (es >= 13'sd1) ? (36'(es - 13'sd1) << 23) : 36'd0;
        bits  = ebase + q[35:0] + 36'(inc);
        if (bits >= 36'h07f800000) begin
            case (mode)
                RND_NEAREST: to_inf = 1'b1;
                RND_ZERO:    to_inf = 1'b0;
                RND_UP:      to_inf = !neg;
                RND_DOWN:    to_inf = neg;
                default:     to_inf = 1'b1;
            endcase
            return {neg, to_inf ? 31'h7f800000 : 31'h7f7fffff};
        end
        return {neg, bits[30:0]};
    endfunction

endpackage

// ----- hdl/mlsf_core.sv -----
module mlsf_core (
    input  mlsf_pkg::t_item   i_item,
    input  logic              i_rebuild,
    input  mlsf_pkg::t_round  i_round,
    output mlsf_pkg::t_result o_result
);
    import mlsf_pkg::*;

    logic [21:0]     synd;
    logic [6:0]      idx;
    t_desc           desc;
    logic [63:0]     addr;
    logic [63:0]     data;
    logic [63:0]     sdata;
    logic            is_line;

    // syndrome and table decode
    always_comb begin
        synd = i_rebuild ? synd_rebuild(i_item.instruction_word) : i_item.syndrome[21:0];
        idx  = {synd[16:15] | synd[19:18], synd[14:10]};
        desc = op_decode(idx);
        is_line = (idx == IDX_LINE_ZERO);
        addr = is_line ? (i_item.fault_address - (i_item.fault_address % LINE_BYTES))
                       : i_item.fault_address;
    end

    // data select, float narrowing, swap, sign extension and store data sizing
    always_comb begin
        data = 64'd0;
        if (desc.kind[K_LOAD]) begin
            case (desc.nbytes)
                NB_W'(2): data = {48'd0, i_item.memory_bytes[63:48]};
                NB_W'(4): data = {32'd0, i_item.memory_bytes[63:32]};
                NB_W'(8): data = i_item.memory_bytes;
                default:  data = 64'd0;
            endcase
        end
        if (desc.kind[K_STORE]) begin
            if (desc.kind[K_FLT]) begin
                data = (desc.nbytes == NB_W'(4))
                     ? {32'd0, narrow_double(i_item.fpr_value, i_round)}
                     : i_item.fpr_value;
            end else begin
                data = i_item.gpr_value;
            end
        end
        if (desc.kind[K_BSWAP]) begin
            if (desc.nbytes == NB_W'(2)) begin
                data = {data[63:16], data[7:0], data[15:8]};
            end else begin
                data = {data[63:32], data[7:0], data[15:8], data[23:16], data[31:24]};
            end
        end
        if (desc.kind[K_SEXT]) begin
            if (desc.nbytes == NB_W'(2)) begin
                data = {{48{data[15]}}, data[15:0]};
            end else begin
                data = {{32{data[31]}}, data[31:0]};
            end
        end
        case (desc.nbytes)
            NB_W'(2): sdata = {48'd0, data[15:0]};
            NB_W'(4): sdata = {32'd0, data[31:0]};
            NB_W'(8): sdata = data;
            default:  sdata = 64'd0;
        endcase
        if (is_line) begin
            sdata = 64'd0;
        end
    end

    // result assembly
    always_comb begin
        o_result = '0;
        o_result.status = ST_HANDLED;
        if (desc.nbytes == '0 || desc.kind[K_MULTI]) begin
            o_result.status = ST_UNSUPPORTED;
        end else if (i_item.access_fault) begin
            o_result.status = ST_BAD_ADDR;
        end else begin
            if (desc.kind[K_LOAD]) begin
                o_result.target_reg = synd[9:5];
                if (desc.kind[K_FLT]) begin
                    o_result.fpr_write    = 1'b1;
                    o_result.target_value = (desc.nbytes == NB_W'(4))
                                          ? widen_single(data[31:0]) : data;
                end else begin
                    o_result.gpr_write    = 1'b1;
                    o_result.target_value = data;
                end
            end
            if (desc.kind[K_STORE]) begin
                o_result.store_enable  = 1'b1;
                o_result.store_address = addr;
                o_result.store_length  = desc.nbytes[7:0];
                o_result.store_data    = sdata;
            end
            if (desc.kind[K_UPD]) begin
                o_result.update_base = 1'b1;
                o_result.base_reg    = synd[4:0];
            end
        end
    end

endmodule

// ----- hdl/misaligned_load_store_fixup.sv -----
// Misaligned load/store fixup.
// Input stream (i_s_axis_*): one misaligned access per item. Output stream
// (o_m_axis_*): one result item per input item, in order. A separate config
// write channel (i_cfg_*) sets syndrome rebuild (index 0) and the
// double-to-single rounding mode (index 1); it is always ready and should
// only be written while no item is in flight.
// The block is a two-register pipeline: an input register feeds the decode,
// swap, sign-extend and float conversion logic, whose answer is caught in
// the output register. An accepted item passes the input register and then
// the output register before o_m_axis_tvalid rises and the result handshake
// can come; one item is accepted every cycle while the output is drained.
// When the receiver stalls, the result holds in the output register and the
// input register still takes one more item; after that tready falls until
// the output moves again. Nothing is lost or repeated.
// Reset (synchronous, active low) empties both registers and sets both
// config registers to 0; there is no other state.
module misaligned_load_store_fixup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // syndrome, instruction_word, fault_address, memory_bytes, gpr_value,
    // fpr_value, access_fault, zero pad
    input  logic [mlsf_pkg::IN_W-1:0]     i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // status, gpr_write, fpr_write, target_reg, target_value, update_base,
    // base_reg, store_enable, store_address, store_length, store_data
    output logic [mlsf_pkg::OUT_W-1:0]    o_m_axis_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [7:0]                    i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);
    import mlsf_pkg::*;

    logic    r_rebuild;
    t_round  r_round;
    logic    r_s1_valid;
    t_item   r_s1_item;
    logic    r_out_valid;
    t_result r_out;
    t_result core_res;
    t_item   in_item;
    logic    out_ready;
    logic    s1_ready;

    // config registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rebuild <= 1'b0;
            r_round   <= RND_NEAREST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_REBUILD) begin
                r_rebuild <= i_cfg_data[0];
            end else if (i_cfg_index == CFG_ROUND) begin
                r_round <= t_round'(i_cfg_data[1:0]);
            end
        end
    end

    // unpack input item
    always_comb begin
        in_item.syndrome         = i_s_axis_tdata[31:0];
        in_item.instruction_word = i_s_axis_tdata[63:32];
        in_item.fault_address    = i_s_axis_tdata[127:64];
        in_item.memory_bytes     = i_s_axis_tdata[191:128];
        in_item.gpr_value        = i_s_axis_tdata[255:192];
        in_item.fpr_value        = i_s_axis_tdata[319:256];
        in_item.access_fault     = i_s_axis_tdata[320];
    end

    // pipeline flow control
    assign out_ready       = !r_out_valid || i_m_axis_tready;
    assign s1_ready        = !r_s1_valid || out_ready;
    assign o_s_axis_tready = s1_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (s1_ready && i_s_axis_tvalid) begin
            r_s1_item <= in_item;
        end
    end

    mlsf_core u_core (
        .i_item   (r_s1_item),
        .i_rebuild(r_rebuild),
        .i_round  (r_round),
        .o_result (core_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (out_ready && r_s1_valid) begin
            r_out <= core_res;
        end
    end

    // pack result item
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.store_data, r_out.store_length, r_out.store_address,
                              r_out.store_enable, r_out.base_reg, r_out.update_base,
                              r_out.target_value, r_out.target_reg, r_out.fpr_write,
                              r_out.gpr_write, r_out.status};

`ifndef SYNTHESIS
    a_not_handled_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != ST_HANDLED |->
            !r_out.store_enable && !r_out.gpr_write && !r_out.fpr_write
            && !r_out.update_base)
        else $error("failed access carries side effects");
    a_one_write_file: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.gpr_write && r_out.fpr_write))
        else $error("load writes both register files");
    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_ready |=> r_s1_valid)
        else $error("stalled item dropped from input register");
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_axis_tready |=> r_out_valid && $stable(r_out))
        else $error("stalled result changed");
`endif

endmodule

// ----- verif/misaligned_load_store_fixup_test.sv -----
module misaligned_load_store_fixup_test;
    import mlsf_pkg::*;

    // decode flags, as bits of the kind byte
    localparam logic [7:0] FL_LD   = 8'h01;
    localparam logic [7:0] FL_ST   = 8'h02;
    localparam logic [7:0] FL_SX   = 8'h04;
    localparam logic [7:0] FL_FP   = 8'h08;
    localparam logic [7:0] FL_UPD  = 8'h10;
    localparam logic [7:0] FL_MUL  = 8'h20;
    localparam logic [7:0] FL_SWAP = 8'h40;

    localparam int NUM_CHUNKS = 6;
    localparam int CHUNK_ITEMS = 155;

    // result field layout inside tdata, lowest bit first
    localparam int NFIELDS = 11;
    localparam int FLD_LO [NFIELDS] = '{0, 2, 3, 4, 9, 73, 74, 79, 80, 144, 152};
    localparam int FLD_W  [NFIELDS] = '{2, 1, 1, 5, 64, 1, 5, 1, 64, 8, 64};
    localparam string FLD_NAME [NFIELDS] = '{"status", "gpr_write", "fpr_write",
        "target_reg", "target_value", "update_base", "base_reg", "store_enable",
        "store_address", "store_length", "store_data"};

    // access decode table: {byte count, kind}
    function automatic logic [15:0] access_kind(input logic [6:0] idx);
        logic [7:0] lb;
        lb = 8'(LINE_BYTES);
        case (idx)
            7'd0, 7'd96:   return {8'd4, FL_LD};
            7'd2, 7'd98:   return {8'd4, FL_ST};
            7'd4, 7'd100:  return {8'd2, FL_LD};
            7'd5, 7'd101:  return {8'd2, FL_LD | FL_SX};
            7'd6, 7'd102:  return {8'd2, FL_ST};
            7'd7:          return {8'd4, FL_LD | FL_MUL};
            7'd8, 7'd104:  return {8'd4, FL_LD | FL_FP};
            7'd9, 7'd105:  return {8'd8, FL_LD | FL_FP};
            7'd10, 7'd106: return {8'd4, FL_ST | FL_FP};
            7'd11, 7'd107: return {8'd8, FL_ST | FL_FP};
            7'd13, 7'd32:  return {8'd8, FL_LD};
            7'd15, 7'd34:  return {8'd8, FL_ST};
            7'd16, 7'd112: return {8'd4, FL_LD | FL_UPD};
            7'd18, 7'd114: return {8'd4, FL_ST | FL_UPD};
            7'd20, 7'd116: return {8'd2, FL_LD | FL_UPD};
            7'd21, 7'd117: return {8'd2, FL_LD | FL_SX | FL_UPD};
            7'd22, 7'd118: return {8'd2, FL_ST | FL_UPD};
            7'd23:         return {8'd4, FL_ST | FL_MUL};
            7'd24, 7'd120: return {8'd4, FL_LD | FL_FP | FL_UPD};
            7'd25, 7'd121: return {8'd8, FL_LD | FL_FP | FL_UPD};
            7'd26, 7'd122: return {8'd4, FL_ST | FL_FP | FL_UPD};
            7'd27, 7'd123: return {8'd8, FL_ST | FL_FP | FL_UPD};
            7'd37, 7'd77:  return {8'd4, FL_LD | FL_SX};
            7'd45, 7'd48:  return {8'd8, FL_LD | FL_UPD};
            7'd47, 7'd50:  return {8'd8, FL_ST | FL_UPD};
            7'd53:         return {8'd4, FL_LD | FL_SX | FL_UPD};
            7'd72:         return {8'd4, FL_LD | FL_SWAP};
            7'd74:         return {8'd4, FL_ST | FL_SWAP};
            7'd76:         return {8'd2, FL_LD | FL_SWAP};
            7'd78:         return {8'd2, FL_ST | FL_SWAP};
            7'd95:         return {lb, FL_ST};
            7'd109:        return {8'd8, FL_LD | FL_MUL};
            7'd111:        return {8'd8, FL_ST | FL_MUL};
            default:       return 16'd0;
        endcase
    endfunction

    // syndrome bits recovered from the instruction encoding
    function automatic logic [31:0] syndrome_of(input logic [31:0] w);
        logic [31:0] s;
        s = {22'd0, w[25:16]};
        if (w[31:26] == OP_EXT) begin
            s[16:15] = w[2:1];
            s[14] = w[6];
            s[13:10] = w[10:7];
        end else begin
            s[14] = w[26];
            s[13:10] = w[30:27];
            if (w[31:26] >= OP_DS_FIRST) s[19:18] = w[1:0];
        end
        return s;
    endfunction

    // single to double, exact
    function automatic logic [63:0] single_to_double(input logic [31:0] s);
        logic [23:0] fr;
        logic [10:0] ex;
        fr = {1'b0, s[22:0]};
        if (s[30:23] == 8'hff) return {s[31], 11'h7ff, s[22:0], 29'd0};
        if (s[30:23] == 8'h00) begin
            if (fr == 24'd0) return {s[31], 63'd0};
            ex = 11'd897;
            while (!fr[23]) begin
                fr = fr << 1;
                ex = ex - 11'd1;
            end
            return {s[31], ex, fr[22:0], 29'd0};
        end
        ex = 11'(s[30:23]) + 11'd896;
        return {s[31], ex, s[22:0], 29'd0};
    endfunction

    // double to single with the selected rounding
    function automatic logic [31:0] double_to_single(input logic [63:0] d, input t_round md);
        logic neg;
        int unsigned ex;
        int es;
        int s2;
        int unsigned sh;
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] bits;
        logic inc;
        logic to_inf;
        neg = d[63];
        ex = 32'(d[62:52]);
        sh = 29;
        if (ex == 2047) begin
            if (d[51:0] == 52'd0) return {neg, 31'h7f800000};
            return {neg, 8'hff, 1'b1, d[50:29]};
        end
        if (ex == 0) begin
            if (d[51:0] == 52'd0) return {neg, 31'd0};
            m = {12'd0, d[51:0]};
            ex = 1;
        end else begin
            m = {11'd0, 1'b1, d[51:0]};
        end
        es = int'(ex) - 896;
        if (es < 1) begin
            s2 = 30 - es;
            sh = (s2 > 63) ? 63 : s2;
        end
        q = m >> sh;
        rem = m & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        case (md)
            RND_NEAREST: inc = (rem > half) || (rem == half && q[0]);
            RND_ZERO:    inc = 1'b0;
            RND_UP:      inc = !neg && rem != 64'd0;
            default:     inc = neg && rem != 64'd0;
        endcase
        if (inc) q = q + 64'd1;
        bits = ((es >= 1) ? (64'(es - 1) << 23) : 64'd0) + q;
        if (bits >= 64'h7f800000) begin
            case (md)
                RND_NEAREST: to_inf = 1'b1;
                RND_ZERO:    to_inf = 1'b0;
                RND_UP:      to_inf = !neg;
                default:     to_inf = neg;
            endcase
            return {neg, to_inf ? 31'h7f800000 : 31'h7f7fffff};
        end
        return {neg, bits[30:0]};
    endfunction

    // expected fixup answers, oldest first
    class fixup_scoreboard;
        logic [OUT_W-1:0] pending_fixups[$];
        bit rebuild;
        t_round rnd;
        int unsigned n_in;
        int unsigned n_out;
        int unsigned n_handled;
        int unsigned n_unsup;
        int unsigned n_bad;

        function void note_access(input logic [IN_W-1:0] it);
            logic [31:0] synd;
            logic [63:0] addr;
            logic [63:0] data;
            logic [6:0] idx;
            logic [7:0] nb;
            logic [7:0] kd;
            logic [15:0] dk;
            logic [1:0] st;
            logic gw, fw, ub, se;
            logic [4:0] treg, breg;
            logic [63:0] tval, saddr, sdata;
            logic [7:0] slen;
            synd = rebuild ? syndrome_of(it[63:32]) : it[31:0];
            addr = it[127:64];
            idx = synd[16:10] | {synd[19:18], 5'd0};
            dk = access_kind(idx);
            nb = dk[15:8];
            kd = dk[7:0];
            st = ST_HANDLED;
            {gw, fw, ub, se} = 4'd0;
            treg = 5'd0;
            breg = 5'd0;
            tval = 64'd0;
            saddr = 64'd0;
            sdata = 64'd0;
            slen = 8'd0;
            data = 64'd0;
            n_in++;
            if (dk == 16'd0 || (kd & FL_MUL) != 0) begin
                st = ST_UNSUPPORTED;
                n_unsup++;
            end else if (it[320]) begin
                st = ST_BAD_ADDR;
                n_bad++;
            end else begin
                n_handled++;
                if (idx == IDX_LINE_ZERO) addr = addr & ~64'(LINE_BYTES - 1);
                if (kd & FL_LD)
                    data = (nb == 8'd8) ? it[191:128] : it[191:128] >> (64 - 8 * nb);
                if (kd & FL_ST) begin
                    if (kd & FL_FP)
                        data = (nb == 8'd4) ? {32'd0, double_to_single(it[319:256], rnd)}
                                            : it[319:256];
                    else
                        data = it[255:192];
                end
                if (kd & FL_SWAP) begin
                    if (nb == 8'd2) data = {data[63:16], data[7:0], data[15:8]};
                    else data = {data[63:32], data[7:0], data[15:8], data[23:16], data[31:24]};
                end
                if (kd & FL_SX) begin
                    if (nb == 8'd2) data = {{48{data[15]}}, data[15:0]};
                    else data = {{32{data[31]}}, data[31:0]};
                end
                if (kd & FL_LD) begin
                    treg = synd[9:5];
                    if (kd & FL_FP) begin
                        fw = 1'b1;
                        tval = (nb == 8'd4) ? single_to_double(data[31:0]) : data;
                    end else begin
                        gw = 1'b1;
                        tval = data;
                    end
                end
                if (kd & FL_ST) begin
                    se = 1'b1;
                    saddr = addr;
                    slen = nb;
                    if (idx == IDX_LINE_ZERO || nb > 8'd8 || nb == 8'd0) sdata = 64'd0;
                    else if (nb == 8'd8) sdata = data;
                    else sdata = data & ((64'd1 << (8 * nb)) - 64'd1);
                end
                if (kd & FL_UPD) begin
                    ub = 1'b1;
                    breg = synd[4:0];
                end
            end
            pending_fixups.push_back({sdata, slen, saddr, se, breg, ub, tval, treg, fw, gw, st});
        endfunction

        // returns an empty string when the result agrees
        function string check_result(input logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            logic [63:0] a;
            logic [63:0] b;
            logic [63:0] mask;
            string msg;
            msg = "";
            n_out++;
            if (pending_fixups.size() == 0) return "result item with nothing expected";
            want = pending_fixups.pop_front();
            for (int i = 0; i < NFIELDS; i++) begin
                mask = (FLD_W[i] == 64) ? '1 : ((64'd1 << FLD_W[i]) - 64'd1);
                a = (got >> FLD_LO[i]) & mask;
                b = (want >> FLD_LO[i]) & mask;
                if (a !== b)
                    msg = {msg, $sformatf(" %s got %h want %h", FLD_NAME[i], a, b)};
            end
            if (msg != "") msg = $sformatf("result %0d:%s", n_out, msg);
            return msg;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_s_axis_tvalid;
    logic o_s_axis_tready;
    logic [IN_W-1:0] i_s_axis_tdata;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready;
    logic [OUT_W-1:0] o_m_axis_tdata;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [7:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    fixup_scoreboard sb;
    int errors;
    int src_idle;
    int snk_idle;
    int hold_cycles;

    logic [6:0] supported_idx [$];

    misaligned_load_store_fixup uut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH %s", msg);
        errors++;
    endtask

    // watch both handshakes at the rising edge
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) sb.note_access(i_s_axis_tdata);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                msg = sb.check_result(o_m_axis_tdata);
                if (msg != "") report_mismatch(msg);
            end
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready = 1'b0;
        end else if (hold_cycles > 0) begin
            i_m_axis_tready = 1'b0;
            hold_cycles--;
        end else begin
            i_m_axis_tready = ($urandom_range(99) >= snk_idle);
        end
    end

    // one item on the input stream; leaves the caller at a falling edge
    task automatic send_access(input logic [IN_W-1:0] d);
        while ($urandom_range(99) < src_idle) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata = d;
        forever begin
            @(posedge i_clk);
            if (o_s_axis_tready) break;
        end
        @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [7:0] idx, input logic [7:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        if (idx == CFG_REBUILD) sb.rebuild = val[0];
        else sb.rnd = t_round'(val[1:0]);
    endtask

    // wait for all answers, then let the pipeline settle
    task automatic drain();
        i_s_axis_tvalid = 1'b0;
        while (sb.pending_fixups.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_single();
        logic [31:0] s;
        s = $urandom;
        case ($urandom_range(5))
            0: s[30:23] = 8'hff;
            1: s[30:23] = 8'h00;
            2: s[30:0] = 31'd0;
            default: ;
        endcase
        return s;
    endfunction

    function automatic logic [63:0] pick_double();
        logic [63:0] d;
        d = {$urandom, $urandom};
        case ($urandom_range(9))
            0: d[62:52] = 11'h7ff;
            1: d[62:52] = 11'h000;
            2: d[62:52] = 11'(840 + $urandom_range(80));
            3: d[62:52] = 11'(1145 + $urandom_range(15));
            4: d[28:0] = 29'h10000000;
            5: d[62:0] = {7'h47, 4'hf, $urandom_range(1) ? 52'hfffffe0000000 : 52'hfffffffffffff};
            default: d[62:52] = 11'(1023 - 60 + $urandom_range(120));
        endcase
        return d;
    endfunction

    function automatic logic [IN_W-1:0] make_access(input logic [6:0] idx, input bit fault);
        logic [31:0] synd;
        logic [31:0] insn;
        logic [63:0] addr;
        logic [63:0] mem;
        synd = $urandom;
        synd[16:10] = idx;
        if ($urandom_range(5) != 0) synd[19:18] = 2'b00;
        insn = $urandom;
        case ($urandom_range(3))
            0: insn[31:26] = OP_EXT;
            1: insn[31:26] = 6'(56 + $urandom_range(7));
            default: ;
        endcase
        addr = {$urandom, $urandom};
        if ($urandom_range(15) == 0) addr = $urandom_range(1) ? '1 : '0;
        mem = {$urandom, $urandom};
        if ($urandom_range(1)) mem[63:32] = pick_single();
        return {7'd0, fault, pick_double(), 32'($urandom), 32'($urandom), mem, addr, insn, synd};
    endfunction

    initial begin
        logic [IN_W-1:0] it;
        logic [6:0] dir_idx [$];
        logic [7:0] rb_cfg [NUM_CHUNKS] = '{8'd1, 8'd0, 8'd1, 8'd0, 8'd1, 8'd0};
        t_round rm_cfg [NUM_CHUNKS] = '{RND_DOWN, RND_ZERO, RND_UP, RND_NEAREST,
                                        RND_DOWN, RND_UP};
        sb = new();
        errors = 0;
        src_idle = 0;
        snk_idle = 0;
        hold_cycles = 0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_REBUILD;
        i_cfg_data = 8'd0;
        for (int i = 0; i < 128; i++)
            if (access_kind(7'(i)) != 16'd0 && (access_kind(7'(i)) & FL_MUL) == 0)
                supported_idx.push_back(7'(i));
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: many access shapes, extremes of the data, the special cases
        write_cfg(CFG_REBUILD, 8'd0);
        write_cfg(CFG_ROUND, 8'(RND_NEAREST));
        dir_idx = '{0, 2, 5, 9, 10, 11, 13, 15, 21, 24, 26, 37, 50, 53, 72, 74, 76, 78,
                    95, 7, 111, 1, 64};
        foreach (dir_idx[i]) begin
            it = make_access(dir_idx[i], 1'b0);
            it[IN_W-9:64] = (i % 2) ? '1 : '0;
            if (i == 4) it[319:256] = 64'h7ff0000000000001;
            if (i == 3) it[191:128] = {32'h00000001, 32'd0};
            it[19:18] = 2'b00;
            send_access(it);
        end
        send_access(make_access(7'd2, 1'b1));
        send_access({7'd0, 1'b1, {256{1'b1}}, {32{1'b1}}, 32'h0000_5f00});
        drain();

        // random chunks under changing settings and idling
        for (int c = 0; c < NUM_CHUNKS; c++) begin
            write_cfg(CFG_REBUILD, rb_cfg[c]);
            write_cfg(CFG_ROUND, 8'(rm_cfg[c]));
            src_idle = (c < 2) ? 29 : (c < 4) ? 78 : 0;
            snk_idle = (c < 2) ? 78 : (c < 4) ? 29 : 0;
            for (int n = 0; n < CHUNK_ITEMS; n++) begin
                if (c == 4 && n == 30) hold_cycles = 120;
                it = make_access($urandom_range(4) != 0 ?
                                 supported_idx[$urandom_range(supported_idx.size() - 1)] :
                                 7'($urandom), $urandom_range(7) == 0);
                send_access(it);
            end
            drain();
        end

        // final wait with a limit
        for (int w = 0; w < 1000 && sb.pending_fixups.size() != 0; w++) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (sb.pending_fixups.size() != 0)
            report_mismatch($sformatf("%0d expected results never came",
                                      sb.pending_fixups.size()));
        $display("covered %0d accesses, %0d results: %0d handled, %0d unsupported, %0d faulted",
                 sb.n_in, sb.n_out, sb.n_handled, sb.n_unsup, sb.n_bad);
        $display("both syndrome sources, all four rounding modes, stalls on either side");
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // run limit
    initial begin
        #3000000;
        $display("timeout");
        $display("Test completed with failures");
        $finish;
    end

endmodule
